// ----- hw/rtl/napr_pkg.sv -----
// Shared constants for the neighbor average prediction residual block.
package napr_pkg;

    // Field and register widths
    localparam int PIXEL_W   = 8;
    localparam int CFG_W     = 13;
    localparam int ROW_W     = 12;
    localparam int APB_W     = 32;
    localparam int APB_ADDR_W = 3;

    // Frame geometry
    localparam int MAX_WIDTH_DEFAULT = 4096;
    localparam int MAX_HEIGHT        = 4096;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd512;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd512;

    // Register index codes (paddr[2])
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Residual arithmetic
    localparam logic [PIXEL_W:0]   RESIDUAL_OFFSET = 9'd128;
    localparam logic [PIXEL_W:0]   PIXEL_MAX       = 9'd255;
    // x/3 == (x*683) >> 11 for every x up to 3*255
    localparam logic [9:0]         DIV3_RECIP      = 10'd683;
    localparam int                 DIV3_SHIFT      = 11;

endpackage

// ----- hw/rtl/neighbor_average_prediction_residual_top.sv -----
// Top level: three-neighbor average DPCM predictor with saturated residual output.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_pixel[7:0]
//  output    out        o_valid / i_stall    o_residual[7:0], o_frame_end
//  config    in         APB psel/penable     image_width @0x0, image_height @0x4
//
// One pixel per cycle while i_stall is low; an accepted pixel passes stage 1, then
// the output register. The row buffer is read and written at the same address on
// the accept edge (read-first), so the pixel above is ready in the next cycle with
// no hazard. Synchronous active-low reset clears counters, left and upper-left
// neighbors and valid bits; the row buffer is not cleared. A stall on the output
// holds the output register; the middle stage keeps accepting until it too is full.
module neighbor_average_prediction_residual_top #(
    parameter int MAX_WIDTH = napr_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // pixel input
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [napr_pkg::PIXEL_W-1:0]      i_pixel,
    // residual output
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [napr_pkg::PIXEL_W-1:0]      o_residual,
    output logic                              o_frame_end,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [napr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [napr_pkg::APB_W-1:0]        pwdata,
    output logic [napr_pkg::APB_W-1:0]        prdata,
    output logic                              pready
);

    localparam int PW = napr_pkg::PIXEL_W;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > napr_pkg::CFG_W) ? CW + 1 : napr_pkg::CFG_W;
    localparam int RW = napr_pkg::ROW_W;
    localparam int HW = napr_pkg::CFG_W;
    localparam logic [CW:0]   MAXW_SLOT = (CW + 1)'(MAX_WIDTH);
    localparam logic [CW-1:0] LAST_SLOT = CW'(MAX_WIDTH - 1);
    localparam logic [WW-1:0] MAXW_EXT  = WW'(MAX_WIDTH);
    localparam logic [HW-1:0] MAXH_EXT  = HW'(napr_pkg::MAX_HEIGHT);

    // Configuration registers
    logic [napr_pkg::CFG_W-1:0] r_img_w, r_img_h;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= napr_pkg::WIDTH_RESET;
            r_img_h <= napr_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                napr_pkg::REG_IMAGE_WIDTH:  r_img_w <= pwdata[napr_pkg::CFG_W-1:0];
                napr_pkg::REG_IMAGE_HEIGHT: r_img_h <= pwdata[napr_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            napr_pkg::REG_IMAGE_WIDTH:  prdata = napr_pkg::APB_W'(r_img_w);
            napr_pkg::REG_IMAGE_HEIGHT: prdata = napr_pkg::APB_W'(r_img_h);
            default:                    prdata = '0;
        endcase
    end

    // Pipeline control
    logic r_s1_valid, r_out_valid;
    logic out_free, s1_adv, in_ready, accept;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && out_free;
    assign in_ready = !r_s1_valid || out_free;
    assign o_stall  = !in_ready;
    assign accept   = i_valid && in_ready;

    // Position counters and frame geometry
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [WW-1:0] w_ext, w_eff, col_next;
    logic [HW-1:0] h_eff, row_next;
    logic [CW-1:0] slot;
    logic          last_col, last_row;

    always_comb begin
        w_ext = WW'(r_img_w);
        if (w_ext == '0)          w_eff = WW'(1);
        else if (w_ext > MAXW_EXT) w_eff = MAXW_EXT;
        else                       w_eff = w_ext;
        if (r_img_h == '0)         h_eff = HW'(1);
        else if (r_img_h > MAXH_EXT) h_eff = MAXH_EXT;
        else                       h_eff = r_img_h;
        col_next = WW'(r_col) + WW'(1);
        row_next = HW'(r_row) + HW'(1);
        last_col = col_next >= w_eff;
        last_row = row_next >= h_eff;
        slot     = ({1'b0, r_col} >= MAXW_SLOT) ? LAST_SLOT : r_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : row_next[RW-1:0];
            end else begin
                r_col <= col_next[CW-1:0];
            end
        end
    end

    // Row buffer: read-first, so the value read is the pixel above
    logic [PW-1:0] r_row_store [MAX_WIDTH];
    logic [PW-1:0] r_above;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_above          <= r_row_store[slot];
            r_row_store[slot] <= i_pixel;
        end
    end

    // Stage 1 registers
    logic [PW-1:0] r_left, r_upper_left;
    logic [PW-1:0] r_s1_pixel, r_s1_left;
    logic          r_s1_row0, r_s1_col0, r_s1_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_left     <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_left     <= i_pixel;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pixel <= i_pixel;
            r_s1_left  <= r_left;
            r_s1_row0  <= (r_row == '0);
            r_s1_col0  <= (r_col == '0);
            r_s1_end   <= last_col && last_row;
        end
    end

    // Upper-left follows the above value of the item leaving stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_left <= '0;
        end else if (s1_adv) begin
            r_upper_left <= r_above;
        end
    end

    // Prediction and saturated residual
    logic [9:0]    nb_sum;
    logic [19:0]   nb_prod;
    logic [PW-1:0] avg3, pred;
    logic [PW:0]   biased, diff;
    logic [PW-1:0] n_residual;

    always_comb begin
        nb_sum  = 10'(r_s1_left) + 10'(r_above) + 10'(r_upper_left);
        nb_prod = 20'(nb_sum) * 20'(napr_pkg::DIV3_RECIP);
        avg3    = nb_prod[napr_pkg::DIV3_SHIFT +: PW];
        if (r_s1_row0)      pred = r_s1_col0 ? '0 : r_s1_left;
        else if (r_s1_col0) pred = r_above;
        else                pred = avg3;
        biased = (PW + 1)'(r_s1_pixel) + napr_pkg::RESIDUAL_OFFSET;
        diff   = biased - (PW + 1)'(pred);
        if (biased < (PW + 1)'(pred))        n_residual = '0;
        else if (diff > napr_pkg::PIXEL_MAX) n_residual = napr_pkg::PIXEL_MAX[PW-1:0];
        else                                 n_residual = diff[PW-1:0];
    end

    // Output register
    logic [PW-1:0] r_residual;
    logic          r_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_residual  <= n_residual;
            r_frame_end <= r_s1_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_residual  = r_residual;
    assign o_frame_end = r_frame_end;

`ifndef SYNTHESIS
    // A full pipeline with a stalled output must hold off the input
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_stall) |-> o_stall)
        else $error("input accepted while pipeline full");

    // The output register only fills from a valid stage-1 item
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> $past(r_s1_valid))
        else $error("output valid without stage-1 transaction");

    // The last pixel of a frame restarts the position at the origin
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last_col && last_row) |=> (r_col == '0 && r_row == '0))
        else $error("position not restarted at frame end");
`endif

endmodule

// ----- tb/neighbor_average_prediction_residual_top_test.sv -----
// Self-checking testbench for the neighbor average prediction residual block.
`timescale 1ns / 1ps

typedef struct packed {
    logic [7:0] residual;
    logic       frame_end;
} t_residual;

// Predicts each residual from the accepted pixel stream and checks the results in order
class t_residual_scoreboard;
    localparam int unsigned MAX_W = napr_pkg::MAX_WIDTH_DEFAULT;
    localparam int unsigned MAX_H = napr_pkg::MAX_HEIGHT;

    logic [12:0]  width_reg;
    logic [12:0]  height_reg;
    logic [7:0]   line_mem [MAX_W];
    logic [7:0]   left_px;
    logic [7:0]   upper_left_px;
    logic [11:0]  col;
    logic [11:0]  row;
    int unsigned  reach;        // line buffer entries [0, reach) have been written
    t_residual    expected_q[$];
    int unsigned  failures;

    function new();
        width_reg     = napr_pkg::WIDTH_RESET;
        height_reg    = napr_pkg::HEIGHT_RESET;
        left_px       = '0;
        upper_left_px = '0;
        col           = '0;
        row           = '0;
        reach         = 0;
        failures      = 0;
    endfunction

    // Register value as the block uses it: zero acts as one, oversize is clamped
    function int unsigned span(logic [12:0] v, int unsigned cap);
        int unsigned x;
        x = 32'(v);
        if (x == 0) return 1;
        if (x > cap) return cap;
        return x;
    endfunction

    // A width change may not make a later row read a line buffer entry never written
    function bit width_fits(logic [12:0] w);
        return row == 0 || span(w, MAX_W) <= reach;
    endfunction

    function int unsigned pixels_to_frame_end();
        int unsigned w, h, rows_after, this_row, c, r;
        w = span(width_reg, MAX_W);
        h = span(height_reg, MAX_H);
        c = 32'(col);
        r = 32'(row);
        rows_after = (r + 1 >= h) ? 0 : h - 1 - r;
        this_row   = (c + 1 >= w) ? 1 : w - c;
        return this_row + rows_after * w;
    endfunction

    function int unsigned outstanding();
        return expected_q.size();
    endfunction

    function void set_register(logic idx, logic [31:0] data);
        if (idx == napr_pkg::REG_IMAGE_WIDTH)
            width_reg = data[12:0];
        else
            height_reg = data[12:0];
    endfunction

    function void check_register(logic idx, logic [31:0] actual);
        logic [31:0] want;
        want = (idx == napr_pkg::REG_IMAGE_WIDTH) ? {19'd0, width_reg} : {19'd0, height_reg};
        if (actual !== want) begin
            failures++;
            $error("prdata mismatch at register %0d: expected %0d, actual %0d",
                   idx, want, actual);
        end
    endfunction

    // Accepted pixel transaction: compute the residual and advance the raster position
    function void take_pixel(logic [7:0] px);
        int unsigned w, h, slot, above, pred, sum;
        bit          last_col, last_row;
        t_residual   r;
        w = span(width_reg, MAX_W);
        h = span(height_reg, MAX_H);
        slot  = (32'(col) < MAX_W) ? 32'(col) : MAX_W - 1;
        above = (slot < reach) ? 32'(line_mem[slot[11:0]]) : 0;
        last_col = (32'(col) + 1 >= w);
        last_row = (32'(row) + 1 >= h);

        // prediction from the neighbors that exist in this frame
        if (row == 0)
            pred = (col == 0) ? 0 : 32'(left_px);
        else if (col == 0)
            pred = above;
        else
            pred = (32'(left_px) + above + 32'(upper_left_px)) / 3;

        // residual with offset, saturated to a byte
        sum = 32'(px) + 32'(napr_pkg::RESIDUAL_OFFSET);
        if (sum < pred) begin
            sum = 0;
        end else begin
            sum = sum - pred;
            if (sum > 32'(napr_pkg::PIXEL_MAX)) sum = 32'(napr_pkg::PIXEL_MAX);
        end
        r.residual  = sum[7:0];
        r.frame_end = last_col && last_row;
        expected_q.push_back(r);

        // neighbor and line buffer update
        upper_left_px  = above[7:0];
        line_mem[slot[11:0]] = px;
        if (slot >= reach) reach = slot + 1;
        left_px = px;

        if (last_col) begin
            col = '0;
            row = last_row ? 12'd0 : row + 12'd1;
        end else begin
            col = col + 12'd1;
        end
    endfunction

    // Output transaction: compare against the oldest prediction
    function void check_residual(logic [7:0] residual, logic frame_end);
        t_residual want;
        if (expected_q.size() == 0) begin
            failures++;
            $error("residual %0d frame_end %0b with no pixel outstanding",
                   residual, frame_end);
            return;
        end
        want = expected_q.pop_front();
        if (residual !== want.residual) begin
            failures++;
            $error("residual mismatch: expected %0d, actual %0d",
                   want.residual, residual);
        end
        if (frame_end !== want.frame_end) begin
            failures++;
            $error("frame_end mismatch: expected %0b, actual %0b",
                   want.frame_end, frame_end);
        end
    endfunction
endclass

module neighbor_average_prediction_residual_top_test;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned RANDOM_ITEMS = 1900;

    typedef enum {PX_UNIFORM, PX_EXTREME, PX_SMOOTH} t_pixel_style;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_valid = 1'b0;
    logic                            o_stall;
    logic [napr_pkg::PIXEL_W-1:0]    i_pixel = '0;
    logic                            o_valid;
    logic                            i_stall = 1'b0;
    logic [napr_pkg::PIXEL_W-1:0]    o_residual;
    logic                            o_frame_end;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [napr_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [napr_pkg::APB_W-1:0]      pwdata = '0;
    logic [napr_pkg::APB_W-1:0]      prdata;
    logic                            pready;

    t_residual_scoreboard board;
    bit                   steady = 1'b0;   // no idling on either side while set
    logic [7:0]           last_px = '0;
    int unsigned          cycles = 0;

    neighbor_average_prediction_residual_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_residual  (o_residual),
        .o_frame_end (o_frame_end),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("neighbor_average_prediction_residual_top regression: fail");
        $finish;
    end

    // Output side: random stall, results checked on accept
    always @(negedge i_clk) begin
        i_stall <= i_rst_n && !steady && ($urandom_range(99) < 15);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0)
            board.check_residual(o_residual, o_frame_end);
    end

    function automatic logic [7:0] next_pixel(t_pixel_style style);
        int v;
        case (style)
            PX_EXTREME: begin
                case ($urandom_range(3))
                    0: v = 0;
                    1: v = 1;
                    2: v = 254;
                    default: v = 255;
                endcase
            end
            PX_SMOOTH: begin
                v = int'(last_px) + int'($urandom_range(6)) - 3;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
            default: v = $urandom_range(255);
        endcase
        last_px = v[7:0];
        return v[7:0];
    endfunction

    // Mostly small rows, now and then zero, wide or oversize
    function automatic logic [12:0] pick_width();
        int unsigned roll;
        logic [12:0] w;
        roll = $urandom_range(99);
        if (roll < 55)      w = 13'($urandom_range(1, 8));
        else if (roll < 80) w = 13'($urandom_range(9, 40));
        else if (roll < 87) w = 13'd0;
        else if (roll < 93) w = 13'($urandom_range(41, 300));
        else begin
            case ($urandom_range(3))
                0: w = 13'd4096;
                1: w = 13'd4097;
                2: w = 13'd8191;
                default: w = 13'($urandom_range(4095, 8191));
            endcase
        end
        return w;
    endfunction

    function automatic logic [12:0] pick_height();
        int unsigned roll;
        logic [12:0] h;
        roll = $urandom_range(99);
        if (roll < 55)      h = 13'($urandom_range(1, 6));
        else if (roll < 75) h = 13'($urandom_range(7, 24));
        else if (roll < 85) h = 13'd0;
        else begin
            case ($urandom_range(3))
                0: h = 13'd4096;
                1: h = 13'd4097;
                2: h = 13'd8191;
                default: h = 13'($urandom_range(4095, 8191));
            endcase
        end
        return h;
    endfunction

    // One pixel transaction; called and returns at a falling edge
    task automatic send_pixel(input logic [7:0] px);
        while (!steady && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        board.take_pixel(px);
        @(negedge i_clk);
    endtask

    task automatic send_run(input int unsigned count, input t_pixel_style style);
        repeat (count) send_pixel(next_pixel(style));
        i_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (board.outstanding() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // APB write: setup, access, then idle
    task automatic write_register(input logic idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        board.set_register(idx, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic read_register(input logic idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        board.check_register(idx, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_geometry(input logic [12:0] w, input logic [12:0] h);
        write_register(napr_pkg::REG_IMAGE_WIDTH, {19'd0, w});
        write_register(napr_pkg::REG_IMAGE_HEIGHT, {19'd0, h});
    endtask

    logic [7:0] opening [6] = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd128, 8'd127};

    initial begin
        int unsigned  sent;
        int unsigned  phase;
        int unsigned  n;
        logic [12:0]  w_new;
        logic [12:0]  h_new;
        logic [31:0]  data;
        logic         first_reg;
        logic         reg_idx;
        bit           change_w;
        bit           change_h;
        t_pixel_style style;

        board = new();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values of both registers
        read_register(napr_pkg::REG_IMAGE_WIDTH);
        read_register(napr_pkg::REG_IMAGE_HEIGHT);

        // start of row 0 at reset geometry: saturation high and low
        foreach (opening[k]) send_pixel(opening[k]);
        i_valid <= 1'b0;
        drain_results();

        // shrink mid-row: column already past the new last one wraps at once
        set_geometry(13'd3, 13'd3);
        read_register(napr_pkg::REG_IMAGE_WIDTH);
        send_run(7, PX_EXTREME);
        drain_results();

        // width zero acts as one: every pixel starts a row
        set_geometry(13'd0, 13'd2);
        send_run(4, PX_EXTREME);
        drain_results();

        // one-pixel frames
        set_geometry(13'd1, 13'd1);
        send_run(2, PX_UNIFORM);
        drain_results();

        // oversize width and height clamp to the maximum
        set_geometry(13'd8191, 13'd8191);
        read_register(napr_pkg::REG_IMAGE_WIDTH);
        read_register(napr_pkg::REG_IMAGE_HEIGHT);
        send_run(3, PX_UNIFORM);
        drain_results();

        // height zero mid-row ends the frame on the next pixel
        set_geometry(13'd2, 13'd0);
        send_run(1, PX_UNIFORM);
        drain_results();

        // random phases, each starting from an idle block
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            steady = (phase >= 6 && phase < 12);
            w_new = pick_width();
            h_new = pick_height();
            change_w = ($urandom_range(4) != 0) && board.width_fits(w_new);
            change_h = ($urandom_range(4) != 0);
            first_reg = $urandom_range(1) ? napr_pkg::REG_IMAGE_WIDTH
                                          : napr_pkg::REG_IMAGE_HEIGHT;
            for (int k = 0; k < 2; k++) begin
                reg_idx = (k == 0) ? first_reg : !first_reg;
                data = $urandom;
                if (reg_idx == napr_pkg::REG_IMAGE_WIDTH && change_w) begin
                    data[12:0] = w_new;
                    write_register(napr_pkg::REG_IMAGE_WIDTH, data);
                end else if (reg_idx == napr_pkg::REG_IMAGE_HEIGHT && change_h) begin
                    data[12:0] = h_new;
                    write_register(napr_pkg::REG_IMAGE_HEIGHT, data);
                end
            end
            if (phase % 4 == 0) begin
                read_register(napr_pkg::REG_IMAGE_WIDTH);
                read_register(napr_pkg::REG_IMAGE_HEIGHT);
            end

            style = t_pixel_style'($urandom_range(2));
            if ($urandom_range(2) == 0 && board.pixels_to_frame_end() <= 200)
                n = board.pixels_to_frame_end();
            else
                n = $urandom_range(5, 120);
            send_run(n, style);
            sent += n;
            drain_results();
            phase++;
        end

        steady = 1'b0;
        drain_results();
        repeat (6) @(posedge i_clk);
        if (board.failures == 0 && board.outstanding() == 0)
            $display("neighbor_average_prediction_residual_top regression: pass");
        else
            $display("neighbor_average_prediction_residual_top regression: fail");
        $finish;
    end

endmodule
